/* sv/pis_pkg.sv */
// ----------------------------------------------------------------------------
// pis_pkg: shared constants and types of the per-id pose smoother
// Field widths, register indexes and reset values, result codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pis_pkg;

  // slot table
  localparam int MAX_IDS   = 32;
  localparam int ID_W      = $clog2(MAX_IDS);

  // position fields, signed Q16.16
  localparam int POS_W     = 32;
  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;
  localparam int SQ_W      = 2 * POS_W;

  // configuration registers
  localparam int ALPHA_W   = 17;
  localparam int JUMP_W    = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  // blend product: signed difference times zero-extended alpha
  localparam int DIFF_W    = POS_W + 1;
  localparam int BPROD_W   = DIFF_W + ALPHA_W + 1;
  localparam int FRAC_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP   = 2'd2;

  localparam logic                ENABLE_RST = 1'b1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 17'd6554;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 17'h10000;
  localparam logic [JUMP_W-1:0]   JUMP_RST   = 31'd9830;

  // multiplier operand select: axes 0..2, then the jump limit
  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_JUMP = 2'd3;

  // result codes
  localparam int OUT_W = 2;
  localparam logic [OUT_W-1:0] OUT_PASS   = 2'd0;
  localparam logic [OUT_W-1:0] OUT_LOAD   = 2'd1;
  localparam logic [OUT_W-1:0] OUT_SMOOTH = 2'd2;
  localparam logic [OUT_W-1:0] OUT_SNAP   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              calc_diff;
    logic              clr_acc;
    logic              mul_sq;
    logic              acc_en;
    logic              blend_mul;
    logic              blend_add;
    logic              res_raw;
    logic              mem_we;
    logic              valid_set;
    logic              valid_clr;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } pis_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_valid;
    logic outlier;
  } pis_sts_t;

endpackage

/* sv/pis_if.sv */
// ----------------------------------------------------------------------------
// pis_if: item channels of the pose smoother
// Input channel carries id and raw position, output channel the smoothed
// position and the outcome code. Valid/ready handshake.
// ----------------------------------------------------------------------------
interface pis_in_if;
  logic                               valid;
  logic                               ready;
  logic [pis_pkg::ID_W-1:0]           target_id;
  logic signed [pis_pkg::POS_W-1:0]   raw_x;
  logic signed [pis_pkg::POS_W-1:0]   raw_y;
  logic signed [pis_pkg::POS_W-1:0]   raw_z;

  modport source (output valid, target_id, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, target_id, raw_x, raw_y, raw_z, output ready);
endinterface

interface pis_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pis_pkg::POS_W-1:0]   smooth_x;
  logic signed [pis_pkg::POS_W-1:0]   smooth_y;
  logic signed [pis_pkg::POS_W-1:0]   smooth_z;
  logic [pis_pkg::OUT_W-1:0]          outcome;

  modport source (output valid, smooth_x, smooth_y, smooth_z, outcome, input ready);
  modport sink   (input valid, smooth_x, smooth_y, smooth_z, outcome, output ready);
endinterface

/* sv/pis_ctrl.sv */
// ----------------------------------------------------------------------------
// pis_ctrl: sequencer of the pose smoother
// Walks one item through read, difference and, as needed, squared distance,
// outlier check and per-axis blend, then hands it to the output register.
// ----------------------------------------------------------------------------
module pis_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pis_pkg::OUT_W-1:0]   outcome_o,
  input  logic                        enable_i,
  input  pis_pkg::pis_sts_t           sts_i,
  output pis_pkg::pis_cmd_t           cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_BMUL = 3'd5;
  localparam logic [2:0] S_BADD = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                  state_q, state_d;
  logic [pis_pkg::AXIS_W-1:0]  step_q, step_d;
  logic [pis_pkg::OUT_W-1:0]   code_q, code_d;
  logic                        wr_q, wr_d;
  logic                        out_valid_q, out_valid_d;
  logic [pis_pkg::OUT_W-1:0]   out_code_q, out_code_d;
  logic                        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    code_d      = code_q;
    wr_d        = wr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_code_d  = out_code_q;
    cmd_o       = '0;
    cmd_o.axis  = step_q;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        cmd_o.clr_acc   = 1'b1;
        step_d          = '0;
        if (!enable_i) begin
          cmd_o.valid_clr = 1'b1;
          cmd_o.res_raw   = 1'b1;
          code_d          = pis_pkg::OUT_PASS;
          wr_d            = 1'b0;
          state_d         = S_DONE;
        end else if (!sts_i.slot_valid) begin
          cmd_o.valid_set = 1'b1;
          cmd_o.res_raw   = 1'b1;
          code_d          = pis_pkg::OUT_LOAD;
          wr_d            = 1'b1;
          state_d         = S_DONE;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (step_q == pis_pkg::AXIS_JUMP) begin
          state_d = S_CMP;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_SQ;
        end
      end
      S_CMP: begin
        step_d = '0;
        if (sts_i.outlier) begin
          cmd_o.res_raw = 1'b1;
          code_d        = pis_pkg::OUT_SNAP;
          wr_d          = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_BMUL;
        end
      end
      S_BMUL: begin
        cmd_o.blend_mul = 1'b1;
        state_d         = S_BADD;
      end
      S_BADD: begin
        cmd_o.blend_add = 1'b1;
        if (step_q == pis_pkg::AXIS_LAST) begin
          code_d  = pis_pkg::OUT_SMOOTH;
          wr_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_BMUL;
        end
      end
      S_DONE: begin
        // once the output is free: load it, write back the slot if flagged
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.mem_we   = wr_q;
          out_valid_d    = 1'b1;
          out_code_d     = code_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-item bookkeeping
  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    code_q     <= code_d;
    wr_q       <= wr_d;
    out_code_q <= out_code_d;
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = out_code_q;

endmodule

/* sv/pis_dpath.sv */
// ----------------------------------------------------------------------------
// pis_dpath: datapath of the pose smoother
// Slot memory and valid marks, differences, a shared squaring multiplier
// with saturating accumulate, the blend multiplier and the output register.
// ----------------------------------------------------------------------------
module pis_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pis_pkg::pis_cmd_t                   cmd_i,
  output pis_pkg::pis_sts_t                   sts_o,
  input  logic [pis_pkg::ALPHA_W-1:0]         alpha_i,
  input  logic [pis_pkg::JUMP_W-1:0]          max_jump_i,
  input  logic [pis_pkg::ID_W-1:0]            in_id_i,
  input  logic signed [pis_pkg::POS_W-1:0]    in_x_i,
  input  logic signed [pis_pkg::POS_W-1:0]    in_y_i,
  input  logic signed [pis_pkg::POS_W-1:0]    in_z_i,
  output logic signed [pis_pkg::POS_W-1:0]    out_x_o,
  output logic signed [pis_pkg::POS_W-1:0]    out_y_o,
  output logic signed [pis_pkg::POS_W-1:0]    out_z_o
);

  localparam int POS_W   = pis_pkg::POS_W;
  localparam int AXES    = pis_pkg::AXES;
  localparam int DIFF_W  = pis_pkg::DIFF_W;
  localparam int SQ_W    = pis_pkg::SQ_W;
  localparam int BPROD_W = pis_pkg::BPROD_W;
  localparam int ALPHA_W = pis_pkg::ALPHA_W;

  // slot store: {x, y, z} per id
  logic [AXES*POS_W-1:0]         held_mem [pis_pkg::MAX_IDS];
  logic [AXES*POS_W-1:0]         rd_q;
  logic [pis_pkg::MAX_IDS-1:0]   valid_q;

  logic [pis_pkg::ID_W-1:0]      id_q;
  logic signed [POS_W-1:0]       raw_q  [AXES];
  logic signed [POS_W-1:0]       held   [AXES];
  logic signed [DIFF_W-1:0]      diff_c [AXES];
  logic signed [DIFF_W-1:0]      diff_q [AXES];
  logic [POS_W-1:0]              mag_q  [AXES];
  logic signed [POS_W-1:0]       res_q  [AXES];
  logic signed [POS_W-1:0]       out_q  [AXES];

  logic [POS_W-1:0]              sq_op;
  logic [SQ_W-1:0]               sq_c, prod_q, acc_q, lim_q;
  logic [SQ_W:0]                 acc_sum;
  logic [ALPHA_W-1:0]            a_eff;
  logic signed [ALPHA_W:0]       a_op;
  logic signed [BPROD_W-1:0]     bprod_c, bprod_q;

  // held position of the addressed slot
  for (genvar k = 0; k < AXES; k++) begin : g_axis
    assign held[k]   = rd_q[(AXES-1-k)*POS_W +: POS_W];
    assign diff_c[k] = {raw_q[k][POS_W-1], raw_q[k]} - {held[k][POS_W-1], held[k]};
  end

  // memory: read on accept, write back when the item completes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= held_mem[in_id_i];
    end
    if (cmd_i.mem_we) begin
      held_mem[id_q] <= {res_q[0], res_q[1], res_q[2]};
    end
  end

  // valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.valid_set) begin
      valid_q[id_q] <= 1'b1;
    end else if (cmd_i.valid_clr) begin
      valid_q[id_q] <= 1'b0;
    end
  end

  // squaring unit operand: axis magnitude or the jump limit
  assign sq_op   = (cmd_i.axis == pis_pkg::AXIS_JUMP) ? {1'b0, max_jump_i}
                                                      : mag_q[cmd_i.axis];
  assign sq_c    = SQ_W'(sq_op) * SQ_W'(sq_op);
  assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};

  // blend unit: diff * alpha, alpha clamped to 1.0
  assign a_eff   = (alpha_i > pis_pkg::ALPHA_ONE) ? pis_pkg::ALPHA_ONE : alpha_i;
  assign a_op    = $signed({1'b0, a_eff});
  assign bprod_c = BPROD_W'(diff_q[cmd_i.axis]) * BPROD_W'(a_op);

  // item registers and arithmetic steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q     <= in_id_i;
      raw_q[0] <= in_x_i;
      raw_q[1] <= in_y_i;
      raw_q[2] <= in_z_i;
    end
    if (cmd_i.calc_diff) begin
      for (int k = 0; k < AXES; k++) begin
        diff_q[k] <= diff_c[k];
        mag_q[k]  <= diff_c[k][DIFF_W-1] ? POS_W'(-diff_c[k]) : POS_W'(diff_c[k]);
      end
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end
    if (cmd_i.mul_sq) begin
      prod_q <= sq_c;
    end
    if (cmd_i.acc_en) begin
      if (cmd_i.axis == pis_pkg::AXIS_JUMP) begin
        lim_q <= prod_q;
      end else begin
        // saturate on carry out
        acc_q <= acc_sum[SQ_W] ? '1 : acc_sum[SQ_W-1:0];
      end
    end
    if (cmd_i.blend_mul) begin
      bprod_q <= bprod_c;
    end
    if (cmd_i.res_raw) begin
      for (int k = 0; k < AXES; k++) begin
        res_q[k] <= raw_q[k];
      end
    end
    if (cmd_i.blend_add) begin
      // floor shift is the bit-select of the signed product
      res_q[cmd_i.axis] <= held[cmd_i.axis] + bprod_q[pis_pkg::FRAC_W +: POS_W];
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < AXES; k++) begin
        out_q[k] <= res_q[k];
      end
    end
  end

  assign sts_o.slot_valid = valid_q[id_q];
  assign sts_o.outlier    = (max_jump_i != '0) && (acc_q > lim_q);

  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];

endmodule

/* sv/per_id_pose_smoother.sv */
// ----------------------------------------------------------------------------
// per_id_pose_smoother: per-target exponential position smoother
// Passthrough and first load go from the difference step to the output; a
// snapped outlier adds squared distance and outlier check, a smoothed sample
// the per-axis blend too. One item at a time: the next accept waits until
// the result is loaded; the shared squarer makes 4 passes, the blend unit 3.
// Reset clears all slot valid marks at once and restores the register values.
// ----------------------------------------------------------------------------
module per_id_pose_smoother (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pis_in_if.sink                            item_i,
  pis_out_if.source                         result_o,
  input  logic                              cfg_we_i,
  input  logic [pis_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pis_pkg::CFG_W-1:0]         cfg_data_i
);

  logic                           enable_q;
  logic [pis_pkg::ALPHA_W-1:0]    alpha_q;
  logic [pis_pkg::JUMP_W-1:0]     max_jump_q;
  pis_pkg::pis_cmd_t              cmd;
  pis_pkg::pis_sts_t              sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= pis_pkg::ENABLE_RST;
      alpha_q    <= pis_pkg::ALPHA_RST;
      max_jump_q <= pis_pkg::JUMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pis_pkg::CFG_ENABLE: enable_q   <= cfg_data_i[0];
        pis_pkg::CFG_ALPHA:  alpha_q    <= cfg_data_i[pis_pkg::ALPHA_W-1:0];
        pis_pkg::CFG_JUMP:   max_jump_q <= cfg_data_i[pis_pkg::JUMP_W-1:0];
        default: ;
      endcase
    end
  end

  pis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .outcome_o   (result_o.outcome),
    .enable_i    (enable_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pis_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .alpha_i    (alpha_q),
    .max_jump_i (max_jump_q),
    .in_id_i    (item_i.target_id),
    .in_x_i     (item_i.raw_x),
    .in_y_i     (item_i.raw_y),
    .in_z_i     (item_i.raw_z),
    .out_x_o    (result_o.smooth_x),
    .out_y_o    (result_o.smooth_y),
    .out_z_o    (result_o.smooth_z)
  );

  // one item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("second item accepted while one is in flight");

  // a new result is only loaded while the input side is closed
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !item_i.ready)
    else $error("result loaded while accepting items");

  // with the filter off every result is a passthrough
  a_pass_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !enable_q) |-> (result_o.outcome == pis_pkg::OUT_PASS))
    else $error("filtered result while the filter is disabled");

endmodule

/* verif/tb_per_id_pose_smoother.sv */
// ----------------------------------------------------------------------------
// tb_per_id_pose_smoother: self-checking bench for the per-id pose smoother
// A scripted opening walks first loads, saturated and boundary distances,
// alpha and jump extremes and the disabled passthrough. Random phases under
// different register settings then follow, mostly small or jump-sized moves
// around each track with corners and noise mixed in. A local slot model
// predicts every result and both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_per_id_pose_smoother;
  import pis_pkg::*;

  typedef struct {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pose_in_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [OUT_W-1:0]        outcome;
  } pose_out_t;

  typedef struct {
    bit        pinned;
    pose_out_t want;
  } pin_t;

  typedef enum logic {ROW_WRITE, ROW_POSE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    pose_in_t             pose;
    bit                   pinned;
    pose_out_t            want;
  } script_row_t;

  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 192;
  localparam int DRAIN_WAIT = 20;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pis_in_if  item_if ();
  pis_out_if result_if ();

  per_id_pose_smoother dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // slot model and its register copies
  bit                      slot_live [MAX_IDS];
  logic signed [POS_W-1:0] held_pos [MAX_IDS][AXES];
  logic                    cfg_enable = ENABLE_RST;
  logic [ALPHA_W-1:0]      cfg_alpha  = ALPHA_RST;
  logic [JUMP_W-1:0]       cfg_jump   = JUMP_RST;

  pose_out_t   pending_poses [$];
  pin_t        pin_q [$];
  script_row_t script [$];

  int  items_sent;
  int  results_seen;
  int  fail_count;
  int  reg_writes;
  int  outcome_tally [4];
  bit  in_busy;
  bit  cfg_open;
  bit  steady_flow;
  logic [ID_W-1:0] hot_base;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #6000000;
    $display("%0t: timeout, %0d items sent, %0d results seen", $time, items_sent,
             results_seen);
    $display("end of test: mismatches");
    $finish;
  end

  // one item through the slot model
  function automatic pose_out_t smooth_step(pose_in_t it);
    pose_out_t               res;
    logic signed [POS_W-1:0] raw [AXES];
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]       mag;
    logic [SQ_W-1:0]         sq;
    logic [SQ_W-1:0]         lim;
    logic [SQ_W:0]           sq_sum;
    logic [ALPHA_W-1:0]      weight;
    longint                  step;
    int unsigned             i;
    raw[0] = it.x;
    raw[1] = it.y;
    raw[2] = it.z;
    i = it.id;
    res.outcome = OUT_PASS;
    if (!cfg_enable) begin
      slot_live[i] = 1'b0;
    end else if (!slot_live[i]) begin
      for (int k = 0; k < AXES; k++) held_pos[i][k] = raw[k];
      slot_live[i] = 1'b1;
      res.outcome = OUT_LOAD;
    end else begin
      // saturating squared distance, Q32.32
      sq_sum = '0;
      for (int k = 0; k < AXES; k++) begin
        diff = DIFF_W'(raw[k]) - DIFF_W'(held_pos[i][k]);
        mag  = diff[DIFF_W-1] ? -diff : diff;
        sq   = mag[DIFF_W-1] ? '1 : SQ_W'(mag) * SQ_W'(mag);
        sq_sum = sq_sum + (SQ_W+1)'(sq);
        if (sq_sum[SQ_W]) sq_sum = {1'b0, {SQ_W{1'b1}}};
      end
      lim = SQ_W'(cfg_jump) * SQ_W'(cfg_jump);
      if (cfg_jump != '0 && sq_sum[SQ_W-1:0] > lim) begin
        for (int k = 0; k < AXES; k++) held_pos[i][k] = raw[k];
        res.outcome = OUT_SNAP;
      end else begin
        // held + floor(diff * alpha / 2^16), alpha capped at one
        weight = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
        for (int k = 0; k < AXES; k++) begin
          diff = DIFF_W'(raw[k]) - DIFF_W'(held_pos[i][k]);
          step = (longint'(diff) * longint'(weight)) >>> FRAC_W;
          held_pos[i][k] = POS_W'(longint'(held_pos[i][k]) + step);
        end
        res.outcome = OUT_SMOOTH;
      end
    end
    if (res.outcome == OUT_PASS) begin
      res.x = raw[0];
      res.y = raw[1];
      res.z = raw[2];
    end else begin
      res.x = held_pos[i][0];
      res.y = held_pos[i][1];
      res.z = held_pos[i][2];
    end
    return res;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady_flow || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [POS_W-1:0] corner();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // small, jump-sized or large move around a held position
  function automatic logic signed [POS_W-1:0] nudge(logic signed [POS_W-1:0] base);
    int unsigned pick;
    int unsigned span;
    int unsigned delta;
    pick = $urandom_range(0, 99);
    span = (cfg_jump == '0) ? 32'd65536 : 32'(cfg_jump);
    if (pick < 55) delta = $urandom_range(0, 255);
    else if (pick < 90) delta = $urandom_range(0, span);
    else delta = $urandom_range(0, 32'h00FF_FFFF);
    return $urandom_range(0, 1) ? base + delta : base - delta;
  endfunction

  function automatic pose_in_t make_pose();
    pose_in_t                p;
    int unsigned             pick;
    logic signed [POS_W-1:0] c [AXES];
    pick = $urandom_range(0, 99);
    p.id = (pick < 70) ? ID_W'(hot_base + $urandom_range(0, 3)) : ID_W'($urandom);
    pick = $urandom_range(0, 99);
    for (int k = 0; k < AXES; k++) begin
      if (pick < 65) c[k] = nudge(held_pos[p.id][k]);
      else if (pick < 80) c[k] = corner();
      else c[k] = $urandom;
    end
    p.x = c[0];
    p.y = c[1];
    p.z = c[2];
    return p;
  endfunction

  // script builders
  function automatic void put_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    script_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    r.pose    = '{default: '0};
    r.pinned  = 1'b0;
    r.want    = '{default: '0};
    script = {script, r};
  endfunction

  function automatic void put_pose(logic [ID_W-1:0] id, logic signed [POS_W-1:0] x,
                                   logic signed [POS_W-1:0] y,
                                   logic signed [POS_W-1:0] z);
    script_row_t r;
    r.kind    = ROW_POSE;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.pose    = '{id, x, y, z};
    r.pinned  = 1'b0;
    r.want    = '{default: '0};
    script = {script, r};
  endfunction

  function automatic void put_pinned(logic [ID_W-1:0] id, logic signed [POS_W-1:0] x,
                                     logic signed [POS_W-1:0] y,
                                     logic signed [POS_W-1:0] z,
                                     logic signed [POS_W-1:0] ox,
                                     logic signed [POS_W-1:0] oy,
                                     logic signed [POS_W-1:0] oz,
                                     logic [OUT_W-1:0] oc);
    script_row_t r;
    r.kind    = ROW_POSE;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.pose    = '{id, x, y, z};
    r.pinned  = 1'b1;
    r.want    = '{ox, oy, oz, oc};
    script = {script, r};
  endfunction

  // drivers
  task automatic drop_valid();
    if (in_busy) begin
      item_if.valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_open = 1'b1;
    reg_writes++;
  endtask

  task automatic send_item(pose_in_t p, bit pinned, pose_out_t want);
    int   gap;
    pin_t pin;
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = pick_gap();
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk_i);
    end
    pin.pinned = pinned;
    pin.want   = want;
    pin_q = {pin_q, pin};
    item_if.valid     <= 1'b1;
    item_if.target_id <= p.id;
    item_if.raw_x     <= p.x;
    item_if.raw_y     <= p.y;
    item_if.raw_z     <= p.z;
    in_busy = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    drop_valid();
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic set_phase(logic en, logic [ALPHA_W-1:0] a, logic [JUMP_W-1:0] j);
    wait_idle();
    cfg_write(CFG_ENABLE, CFG_W'(en));
    cfg_write(CFG_ALPHA, CFG_W'(a));
    cfg_write(CFG_JUMP, CFG_W'(j));
  endtask

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // register copies follow the write port
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: cfg_enable <= cfg_data_i[0];
        CFG_ALPHA:  cfg_alpha  <= cfg_data_i[ALPHA_W-1:0];
        CFG_JUMP:   cfg_jump   <= cfg_data_i[JUMP_W-1:0];
        default: ;
      endcase
    end
  end

  // predict on every accepted item
  always @(posedge clk_i) begin : predict_items
    pose_in_t  p;
    pose_out_t r;
    pin_t      pin;
    if (rst_ni && item_if.valid && item_if.ready) begin
      p = '{item_if.target_id, item_if.raw_x, item_if.raw_y, item_if.raw_z};
      r = smooth_step(p);
      pin = pin_q.pop_front();
      if (pin.pinned) r = pin.want;
      pending_poses = {pending_poses, r};
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    pose_out_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (pending_poses.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: %h %h %h outcome %0d", $time,
                 result_if.smooth_x, result_if.smooth_y, result_if.smooth_z,
                 result_if.outcome);
      end else begin
        want = pending_poses.pop_front();
        check_field("smooth_x", want.x, result_if.smooth_x);
        check_field("smooth_y", want.y, result_if.smooth_y);
        check_field("smooth_z", want.z, result_if.smooth_z);
        check_field("outcome", POS_W'(want.outcome), POS_W'(result_if.outcome));
        outcome_tally[want.outcome]++;
      end
    end
  end

  // result side back-pressure
  initial begin : drain
    int n;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        result_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin : stimulus
    pose_out_t none;
    none = '{default: '0};
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    item_if.valid     = 1'b0;
    item_if.target_id = '0;
    item_if.raw_x     = '0;
    item_if.raw_y     = '0;
    item_if.raw_z     = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      slot_live[i] = 1'b0;
      for (int k = 0; k < AXES; k++) held_pos[i][k] = '0;
    end

    // opening script, reset register values first
    put_pinned(0, 0, 0, 0, 0, 0, 0, OUT_LOAD);
    put_pinned(0, 0, 0, 0, 0, 0, 0, OUT_SMOOTH);
    put_pinned(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, OUT_LOAD);
    // full-scale move on x and y: distance saturates
    put_pinned(1, 32'h8000_0000, 32'h7FFF_FFFF, 0,
               32'h8000_0000, 32'h7FFF_FFFF, 0, OUT_SNAP);
    put_pinned(31, 1, 2, 3, 1, 2, 3, OUT_LOAD);
    put_pose(31, 101, 202, 303);
    put_pose(31, -5, 0, 1);
    // guard off: even a saturated distance is smoothed
    put_write(CFG_JUMP, 0);
    put_pose(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_pinned(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, OUT_LOAD);
    // widest guard still trips on a saturated sum
    put_write(CFG_ALPHA, CFG_W'(ALPHA_ONE));
    put_write(CFG_JUMP, 31'h7FFF_FFFF);
    put_pinned(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, OUT_SNAP);
    put_pinned(0, 1000, -1000, 5, 1000, -1000, 5, OUT_SMOOTH);
    // alpha zero holds, alpha above one acts as one
    put_write(CFG_ALPHA, 0);
    put_pinned(0, 123, 456, 789, 1000, -1000, 5, OUT_SMOOTH);
    put_write(CFG_ALPHA, 17'h1FFFF);
    put_pinned(0, -7, -8, -9, -7, -8, -9, OUT_SMOOTH);
    // distance equal to the limit smooths, one beyond snaps
    put_write(CFG_JUMP, 1);
    put_pinned(0, -7, -8, -8, -7, -8, -8, OUT_SMOOTH);
    put_pinned(0, -7, -8, -6, -7, -8, -6, OUT_SNAP);
    // disabled: raw passes and marks clear
    put_write(CFG_ENABLE, 0);
    put_pinned(0, 5, 6, 7, 5, 6, 7, OUT_PASS);
    put_pinned(31, 32'h8000_0000, 32'h7FFF_FFFF, 0,
               32'h8000_0000, 32'h7FFF_FFFF, 0, OUT_PASS);
    put_write(CFG_ENABLE, 1);
    put_write(CFG_ALPHA, CFG_W'(ALPHA_RST));
    put_write(CFG_JUMP, CFG_W'(JUMP_RST));
    put_pinned(0, 9, 9, 9, 9, 9, 9, OUT_LOAD);
    put_pinned(31, 10, 10, 10, 10, 10, 10, OUT_LOAD);
    put_pose(31, 65546, -65526, 100000);
    put_pose(0, 5009, -2991, 9);
    put_pose(0, 5009, -2991, 9);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_item(script[r].pose, script[r].pinned, script[r].want);
      end
    end

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_phase(1'b1, ALPHA_RST, JUMP_RST);
        1: set_phase(1'b1, ALPHA_ONE, '0);
        2: set_phase(1'b1, '0, 31'h7FFF_FFFF);
        3: set_phase(1'b1, 17'h1FFFF, 31'd1);
        4: set_phase(1'b0, ALPHA_W'($urandom), JUMP_W'($urandom));
        5: set_phase(1'b1, 17'd1, 31'd65536);
        6: set_phase(1'b1, ALPHA_W'($urandom_range(0, 131071)),
                     JUMP_W'($urandom_range(1, 1 << 20)));
        default: set_phase(1'b1, 17'd32768, 31'd9830);
      endcase
      steady_flow = (ph % 3 == 2);
      hot_base = ID_W'($urandom);
      repeat (PHASE_LEN) send_item(make_pose(), 1'b0, none);
    end

    wait_idle();
    steady_flow = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_poses.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_poses.size());
    end

    $display("run: %0d poses, %0d register writes", items_sent, reg_writes);
    $display("outcomes: %0d passthrough, %0d first loads, %0d smoothed, %0d snapped",
             outcome_tally[OUT_PASS], outcome_tally[OUT_LOAD],
             outcome_tally[OUT_SMOOTH], outcome_tally[OUT_SNAP]);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pis_pkg.sv
sv/pis_if.sv
sv/pis_ctrl.sv
sv/pis_dpath.sv
sv/per_id_pose_smoother.sv
verif/tb_per_id_pose_smoother.sv
